### rtl/source_text_tokenizer_top_macros.svh
// assertion macros shared by the tokenizer modules
`ifndef SOURCE_TEXT_TOKENIZER_TOP_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_TOP_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define STT_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked on every rising edge out of reset
`define STT_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/stt_pkg.sv
// shared types, codes, character classes and keyword table of the tokenizer
package stt_pkg;

  localparam int STATUS_BITS  = 3;
  localparam int KIND_BITS    = 6;
  localparam int NUM_KEYWORDS = 17;
  localparam int KW_MAX_CHARS = 6;

  typedef logic [STATUS_BITS-1:0] status_t;
  typedef logic [KIND_BITS-1:0]   kind_t;

  // result status codes
  localparam status_t ST_TOKEN       = 3'd0;
  localparam status_t ST_END_OK      = 3'd1;
  localparam status_t ST_BAD_CHAR    = 3'd2;
  localparam status_t ST_BAD_NUMBER  = 3'd3;
  localparam status_t ST_OPEN_STRING = 3'd4;

  // token kinds
  localparam kind_t KIND_NONE     = 6'd0;
  localparam kind_t KIND_ASSIGN   = 6'd8;
  localparam kind_t KIND_LT       = 6'd9;
  localparam kind_t KIND_GT       = 6'd10;
  localparam kind_t KIND_LE       = 6'd11;
  localparam kind_t KIND_GE       = 6'd12;
  localparam kind_t KIND_EQ       = 6'd13;
  localparam kind_t KIND_NE       = 6'd14;
  localparam kind_t KIND_KEYWORD0 = 6'd20;
  localparam kind_t KIND_IDENT    = 6'd37;
  localparam kind_t KIND_INT      = 6'd38;
  localparam kind_t KIND_FLOAT    = 6'd39;
  localparam kind_t KIND_STRING   = 6'd40;

  // characters with a role of their own
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_EQUALS     = 8'h3D;
  localparam logic [7:0] CH_LESS       = 8'h3C;
  localparam logic [7:0] CH_GREATER    = 8'h3E;
  localparam logic [7:0] CH_BANG       = 8'h21;

  // keyword spellings, right-aligned and zero-padded, in kind order
  localparam logic [8*KW_MAX_CHARS-1:0] KW_TEXT [NUM_KEYWORDS] = '{
    "def", "new", "int", "float", "string", "print", "read", "return",
    "break", "if", "else", "for", "and", "or", "not", "call", "null"};
  localparam logic [2:0] KW_LEN [NUM_KEYWORDS] = '{
    3'd3, 3'd3, 3'd3, 3'd5, 3'd6, 3'd5, 3'd4, 3'd6,
    3'd5, 3'd2, 3'd4, 3'd3, 3'd3, 3'd2, 3'd3, 3'd4, 3'd4};

  // result queue push control from the scanner
  typedef struct packed {
    logic valid_a;
    logic valid_b;
  } push_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // one-character tokens: {hit, kind}
  function automatic logic [KIND_BITS:0] single_kind(input logic [7:0] c);
    case (c)
      8'h28:   return {1'b1, 6'd0};   // (
      8'h29:   return {1'b1, 6'd1};   // )
      8'h5B:   return {1'b1, 6'd2};   // [
      8'h5D:   return {1'b1, 6'd3};   // ]
      8'h7B:   return {1'b1, 6'd4};   // {
      8'h7D:   return {1'b1, 6'd5};   // }
      8'h2C:   return {1'b1, 6'd6};   // ,
      8'h3B:   return {1'b1, 6'd7};   // ;
      8'h2A:   return {1'b1, 6'd15};  // *
      8'h2F:   return {1'b1, 6'd16};  // /
      8'h25:   return {1'b1, 6'd17};  // %
      8'h2B:   return {1'b1, 6'd18};  // +
      8'h2D:   return {1'b1, 6'd19};  // -
      default: return {1'b0, 6'd0};
    endcase
  endfunction

endpackage

### rtl/stt_kw_match.sv
// keyword matcher: compares the buffered identifier prefix with the keyword table
module stt_kw_match #(
  parameter int KEYWORD_CHARS = 6,
  parameter int LENGTH_BITS   = 16
) (
  input  logic [7:0]             kbuf [KEYWORD_CHARS],
  input  logic [LENGTH_BITS-1:0] tok_len,
  output stt_pkg::kind_t         kind
);

  logic [stt_pkg::NUM_KEYWORDS-1:0] hit;

  // one comparator per keyword, length first, then each character
  always_comb begin
    for (int i = 0; i < stt_pkg::NUM_KEYWORDS; i++) begin
      hit[i] = (tok_len == LENGTH_BITS'(stt_pkg::KW_LEN[i]));
      for (int j = 0; j < stt_pkg::KW_MAX_CHARS; j++) begin
        if (j < int'(stt_pkg::KW_LEN[i])) begin
          hit[i] = hit[i] &&
                   (kbuf[j] == stt_pkg::KW_TEXT[i][8*(int'(stt_pkg::KW_LEN[i])-1-j) +: 8]);
        end
      end
    end
  end

  // spellings are distinct, so at most one comparator fires
  always_comb begin
    kind = stt_pkg::KIND_IDENT;
    for (int i = 0; i < stt_pkg::NUM_KEYWORDS; i++) begin
      if (hit[i]) begin
        kind = stt_pkg::KIND_KEYWORD0 + stt_pkg::KIND_BITS'(i);
      end
    end
  end

endmodule

### rtl/stt_core.sv
// scanner state machine: position tracking, token state and result forming
`include "source_text_tokenizer_top_macros.svh"

module stt_core #(
  parameter int KEYWORD_CHARS = 6,
  parameter int LINE_BITS     = 24,
  parameter int COLUMN_BITS   = 16,
  parameter int OFFSET_BITS   = 32,
  parameter int LENGTH_BITS   = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    char_byte,
  input  logic          end_of_source,
  output stt_pkg::push_t push,
  output logic [stt_pkg::STATUS_BITS+stt_pkg::KIND_BITS+LINE_BITS+COLUMN_BITS+
                OFFSET_BITS+LENGTH_BITS:0] res_a,
  output logic [stt_pkg::STATUS_BITS+stt_pkg::KIND_BITS+LINE_BITS+COLUMN_BITS+
                OFFSET_BITS+LENGTH_BITS:0] res_b
);

  localparam int RW = stt_pkg::STATUS_BITS + stt_pkg::KIND_BITS + LINE_BITS +
                      COLUMN_BITS + OFFSET_BITS + LENGTH_BITS + 1;
  localparam int KI = $clog2(KEYWORD_CHARS);

  // scan modes
  localparam logic [3:0] M_WS    = 4'd0;
  localparam logic [3:0] M_IDENT = 4'd1;
  localparam logic [3:0] M_NUM   = 4'd2;
  localparam logic [3:0] M_FRAC  = 4'd3;
  localparam logic [3:0] M_STR   = 4'd4;
  localparam logic [3:0] M_EQ    = 4'd5;
  localparam logic [3:0] M_GT    = 4'd6;
  localparam logic [3:0] M_LT    = 4'd7;
  localparam logic [3:0] M_BANG  = 4'd8;

  logic [3:0]             mode_r,   mode_nxt;
  logic [LINE_BITS-1:0]   line_r,   line_nxt;
  logic [COLUMN_BITS-1:0] col_r,    col_nxt;
  logic [OFFSET_BITS-1:0] pos_r,    pos_nxt;
  logic [COLUMN_BITS-1:0] tc_r,     tc_nxt;
  logic [OFFSET_BITS-1:0] to_r,     to_nxt;
  logic [LENGTH_BITS-1:0] tl_r,     tl_nxt;
  logic                   halted_r, halted_nxt;
  logic [7:0]             kbuf_r [KEYWORD_CHARS];

  logic                   kb_we;
  logic [KI-1:0]          kb_idx;

  logic [LINE_BITS-1:0]   line_inc;
  logic [COLUMN_BITS-1:0] col_inc;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic [LENGTH_BITS-1:0] tl_inc;

  stt_pkg::kind_t         kw_kind;
  stt_pkg::kind_t         pend_kind;
  logic [stt_pkg::KIND_BITS:0] single;

  // between-tokens handler outputs
  logic [3:0]             ws_mode;
  logic [LINE_BITS-1:0]   ws_line;
  logic [COLUMN_BITS-1:0] ws_col;
  logic [OFFSET_BITS-1:0] ws_pos;
  logic [COLUMN_BITS-1:0] ws_tc;
  logic [OFFSET_BITS-1:0] ws_to;
  logic [LENGTH_BITS-1:0] ws_tl;
  logic                   ws_emit;
  logic                   ws_halt;
  logic                   ws_kb_we;
  stt_pkg::status_t       ws_status;
  stt_pkg::kind_t         ws_kind;

  // result of the pending or current token
  logic                   a_valid;
  stt_pkg::status_t       a_status;
  stt_pkg::kind_t         a_kind;
  logic [LENGTH_BITS-1:0] a_len;
  logic                   take_ws;

  function automatic logic [RW-1:0] pack_res(
    input stt_pkg::status_t       st,
    input stt_pkg::kind_t         kd,
    input logic [LINE_BITS-1:0]   ln,
    input logic [COLUMN_BITS-1:0] cl,
    input logic [OFFSET_BITS-1:0] of,
    input logic [LENGTH_BITS-1:0] lg,
    input logic                   lst
  );
    return {st, kd, ln, cl, of, lg, lst};
  endfunction

  // saturating position increments
  assign line_inc = (&line_r) ? line_r : line_r + 1'b1;
  assign col_inc  = (&col_r)  ? col_r  : col_r  + 1'b1;
  assign pos_inc  = (&pos_r)  ? pos_r  : pos_r  + 1'b1;
  assign tl_inc   = (&tl_r)   ? tl_r   : tl_r   + 1'b1;

  assign single = stt_pkg::single_kind(char_byte);

  // keyword lookup on the buffered identifier
  stt_kw_match #(
    .KEYWORD_CHARS (KEYWORD_CHARS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_kw_match (
    .kbuf    (kbuf_r),
    .tok_len (tl_r),
    .kind    (kw_kind)
  );

  // kind of the token that a terminating byte flushes
  always_comb begin
    case (mode_r)
      M_IDENT: pend_kind = kw_kind;
      M_NUM:   pend_kind = stt_pkg::KIND_INT;
      M_FRAC:  pend_kind = stt_pkg::KIND_FLOAT;
      M_EQ:    pend_kind = stt_pkg::KIND_ASSIGN;
      M_GT:    pend_kind = stt_pkg::KIND_GT;
      M_LT:    pend_kind = stt_pkg::KIND_LT;
      default: pend_kind = stt_pkg::KIND_NONE;
    endcase
  end

  // byte seen between tokens: skip, start a token, emit a one-character token or report a bad character
  always_comb begin
    ws_mode   = M_WS;
    ws_line   = line_r;
    ws_col    = col_r;
    ws_pos    = pos_r;
    ws_tc     = col_r;
    ws_to     = pos_r;
    ws_tl     = LENGTH_BITS'(1);
    ws_emit   = 1'b0;
    ws_halt   = 1'b0;
    ws_kb_we  = 1'b0;
    ws_status = stt_pkg::ST_TOKEN;
    ws_kind   = stt_pkg::KIND_NONE;
    if (stt_pkg::is_space(char_byte)) begin
      ws_tc  = tc_r;
      ws_to  = to_r;
      ws_tl  = tl_r;
      ws_pos = pos_inc;
      if (char_byte == stt_pkg::CH_NEWLINE) begin
        ws_line = line_inc;
        ws_col  = COLUMN_BITS'(1);
      end else begin
        ws_col = col_inc;
      end
    end else if (stt_pkg::is_alpha(char_byte) || char_byte == stt_pkg::CH_UNDERSCORE) begin
      ws_mode  = M_IDENT;
      ws_kb_we = 1'b1;
      ws_col   = col_inc;
      ws_pos   = pos_inc;
    end else if (stt_pkg::is_digit(char_byte)) begin
      ws_mode = M_NUM;
      ws_col  = col_inc;
      ws_pos  = pos_inc;
    end else if (char_byte == stt_pkg::CH_QUOTE) begin
      ws_mode = M_STR;
      ws_to   = pos_inc;
      ws_tl   = '0;
      ws_col  = col_inc;
      ws_pos  = pos_inc;
    end else if (char_byte == stt_pkg::CH_EQUALS || char_byte == stt_pkg::CH_LESS ||
                 char_byte == stt_pkg::CH_GREATER || char_byte == stt_pkg::CH_BANG) begin
      ws_mode = (char_byte == stt_pkg::CH_EQUALS) ? M_EQ :
                (char_byte == stt_pkg::CH_LESS)   ? M_LT :
                (char_byte == stt_pkg::CH_GREATER) ? M_GT : M_BANG;
      ws_col  = col_inc;
      ws_pos  = pos_inc;
    end else if (single[stt_pkg::KIND_BITS]) begin
      ws_emit = 1'b1;
      ws_kind = single[stt_pkg::KIND_BITS-1:0];
      ws_col  = col_inc;
      ws_pos  = pos_inc;
    end else begin
      ws_emit   = 1'b1;
      ws_halt   = 1'b1;
      ws_status = stt_pkg::ST_BAD_CHAR;
    end
  end

  // per-mode step, end-mark flush and result forming
  always_comb begin
    mode_nxt   = mode_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    pos_nxt    = pos_r;
    tc_nxt     = tc_r;
    to_nxt     = to_r;
    tl_nxt     = tl_r;
    halted_nxt = halted_r;
    kb_we      = 1'b0;
    kb_idx     = '0;
    push       = '0;
    res_a      = '0;
    res_b      = '0;
    a_valid    = 1'b0;
    a_status   = stt_pkg::ST_TOKEN;
    a_kind     = stt_pkg::KIND_NONE;
    a_len      = tl_r;
    take_ws    = 1'b0;

    if (end_of_source) begin
      // end mark: flush and report unless halted, then back to the reset state
      if (!halted_r) begin
        case (mode_r)
          M_IDENT, M_NUM, M_FRAC, M_EQ, M_GT, M_LT: begin
            res_a = pack_res(stt_pkg::ST_TOKEN, pend_kind, line_r, tc_r, to_r, tl_r, 1'b0);
            res_b = pack_res(stt_pkg::ST_END_OK, stt_pkg::KIND_NONE, line_r, col_r, pos_r,
                             '0, 1'b1);
            push  = '{valid_a: 1'b1, valid_b: 1'b1};
          end
          M_BANG: begin
            res_a = pack_res(stt_pkg::ST_BAD_CHAR, stt_pkg::KIND_NONE, line_r, tc_r, to_r,
                             LENGTH_BITS'(1), 1'b1);
            push  = '{valid_a: 1'b1, valid_b: 1'b0};
          end
          M_STR: begin
            res_a = pack_res(stt_pkg::ST_OPEN_STRING, stt_pkg::KIND_NONE, line_r, tc_r,
                             to_r, tl_r, 1'b1);
            push  = '{valid_a: 1'b1, valid_b: 1'b0};
          end
          default: begin
            res_a = pack_res(stt_pkg::ST_END_OK, stt_pkg::KIND_NONE, line_r, col_r, pos_r,
                             '0, 1'b1);
            push  = '{valid_a: 1'b1, valid_b: 1'b0};
          end
        endcase
      end
      mode_nxt   = M_WS;
      line_nxt   = LINE_BITS'(1);
      col_nxt    = COLUMN_BITS'(1);
      pos_nxt    = '0;
      tc_nxt     = COLUMN_BITS'(1);
      to_nxt     = '0;
      tl_nxt     = '0;
      halted_nxt = 1'b0;
    end else if (!halted_r) begin
      case (mode_r)
        M_IDENT: begin
          if (stt_pkg::is_alpha(char_byte) || stt_pkg::is_digit(char_byte) ||
              char_byte == stt_pkg::CH_UNDERSCORE) begin
            kb_we   = (tl_r < LENGTH_BITS'(KEYWORD_CHARS));
            kb_idx  = tl_r[KI-1:0];
            tl_nxt  = tl_inc;
            col_nxt = col_inc;
            pos_nxt = pos_inc;
          end else begin
            a_valid = 1'b1;
            a_kind  = pend_kind;
            take_ws = 1'b1;
          end
        end
        M_NUM, M_FRAC: begin
          if (stt_pkg::is_digit(char_byte)) begin
            tl_nxt  = tl_inc;
            col_nxt = col_inc;
            pos_nxt = pos_inc;
          end else if (char_byte == stt_pkg::CH_DOT && mode_r == M_NUM) begin
            tl_nxt   = tl_inc;
            mode_nxt = M_FRAC;
            col_nxt  = col_inc;
            pos_nxt  = pos_inc;
          end else if (stt_pkg::is_alpha(char_byte) ||
                       char_byte == stt_pkg::CH_UNDERSCORE) begin
            a_valid    = 1'b1;
            a_status   = stt_pkg::ST_BAD_NUMBER;
            halted_nxt = 1'b1;
          end else begin
            a_valid = 1'b1;
            a_kind  = pend_kind;
            take_ws = 1'b1;
          end
        end
        M_STR: begin
          if (char_byte == stt_pkg::CH_QUOTE) begin
            a_valid  = 1'b1;
            a_kind   = stt_pkg::KIND_STRING;
            mode_nxt = M_WS;
            col_nxt  = col_inc;
            pos_nxt  = pos_inc;
          end else if (char_byte == stt_pkg::CH_NEWLINE) begin
            a_valid    = 1'b1;
            a_status   = stt_pkg::ST_OPEN_STRING;
            halted_nxt = 1'b1;
          end else begin
            tl_nxt  = tl_inc;
            col_nxt = col_inc;
            pos_nxt = pos_inc;
          end
        end
        M_EQ, M_GT, M_LT: begin
          if (char_byte == stt_pkg::CH_EQUALS) begin
            a_valid  = 1'b1;
            a_len    = LENGTH_BITS'(2);
            a_kind   = (mode_r == M_EQ) ? stt_pkg::KIND_EQ :
                       (mode_r == M_GT) ? stt_pkg::KIND_GE : stt_pkg::KIND_LE;
            tl_nxt   = LENGTH_BITS'(2);
            mode_nxt = M_WS;
            col_nxt  = col_inc;
            pos_nxt  = pos_inc;
          end else begin
            a_valid = 1'b1;
            a_kind  = pend_kind;
            take_ws = 1'b1;
          end
        end
        M_BANG: begin
          if (char_byte == stt_pkg::CH_EQUALS) begin
            a_valid  = 1'b1;
            a_len    = LENGTH_BITS'(2);
            a_kind   = stt_pkg::KIND_NE;
            tl_nxt   = LENGTH_BITS'(2);
            mode_nxt = M_WS;
            col_nxt  = col_inc;
            pos_nxt  = pos_inc;
          end else begin
            a_valid    = 1'b1;
            a_status   = stt_pkg::ST_BAD_CHAR;
            halted_nxt = 1'b1;
          end
        end
        default: begin
          take_ws = 1'b1;
        end
      endcase

      // a terminating byte is handled again as between-tokens input
      if (take_ws) begin
        mode_nxt   = ws_mode;
        line_nxt   = ws_line;
        col_nxt    = ws_col;
        pos_nxt    = ws_pos;
        tc_nxt     = ws_tc;
        to_nxt     = ws_to;
        tl_nxt     = ws_tl;
        halted_nxt = ws_halt;
        kb_we      = ws_kb_we;
        kb_idx     = '0;
        if (a_valid) begin
          res_a = pack_res(a_status, a_kind, line_r, tc_r, to_r, a_len, !ws_emit);
          res_b = pack_res(ws_status, ws_kind, line_r, col_r, pos_r, LENGTH_BITS'(1), 1'b1);
          push  = '{valid_a: 1'b1, valid_b: ws_emit};
        end else begin
          res_a = pack_res(ws_status, ws_kind, line_r, col_r, pos_r, LENGTH_BITS'(1), 1'b1);
          push  = '{valid_a: ws_emit, valid_b: 1'b0};
        end
      end else begin
        res_a = pack_res(a_status, a_kind, line_r, tc_r, to_r, a_len, 1'b1);
        push  = '{valid_a: a_valid, valid_b: 1'b0};
      end
    end

    if (!accept) begin
      push = '0;
    end
  end

  // scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_WS;
      line_r   <= LINE_BITS'(1);
      col_r    <= COLUMN_BITS'(1);
      pos_r    <= '0;
      tc_r     <= COLUMN_BITS'(1);
      to_r     <= '0;
      tl_r     <= '0;
      halted_r <= 1'b0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
      pos_r    <= pos_nxt;
      tc_r     <= tc_nxt;
      to_r     <= to_nxt;
      tl_r     <= tl_nxt;
      halted_r <= halted_nxt;
    end
  end

  // keyword prefix buffer, written only during an identifier
  always_ff @(posedge clk) begin
    if (accept && kb_we) begin
      kbuf_r[kb_idx] <= char_byte;
    end
  end

  // checks
  `STT_ASSERT_NOW(a_halt_quiet, accept && halted_r && !end_of_source, !push.valid_a, "halted scanner produced a result")
  `STT_ASSERT_NEXT(a_end_resets, accept && end_of_source, mode_r == M_WS && !halted_r && tl_r == '0 && pos_r == '0, "end mark did not reset the scanner")

endmodule

### rtl/stt_result_fifo.sv
// result queue: takes up to two results per cycle, hands out one per transaction
`include "source_text_tokenizer_top_macros.svh"

module stt_result_fifo #(
  parameter int WIDTH = 100,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  stt_pkg::push_t   push,
  input  logic [WIDTH-1:0] data_a,
  input  logic [WIDTH-1:0] data_b,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [WIDTH-1:0] out_data,
  output logic             room
);

  // depth is a power of two so the pointers wrap on their own
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r,  count_nxt;
  logic [PW-1:0]    wr_ptr_p1;
  logic             pop;

  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  // two free slots needed before the scanner may take another byte
  assign room      = (count_r <= CW'(DEPTH - 2));
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  // pointer and fill level update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push.valid_a) + PW'(push.valid_b);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    count_nxt  = count_r + CW'(push.valid_a) + CW'(push.valid_b) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push.valid_a) begin
      mem_r[wr_ptr_r] <= data_a;
    end
    if (push.valid_b) begin
      mem_r[wr_ptr_p1] <= data_b;
    end
  end

  // checks
  `STT_ASSERT_NOW(a_push_order, push.valid_b, push.valid_a, "second result pushed without a first")
  `STT_ASSERT_NOW(a_push_room, push.valid_a, room, "result pushed into a full queue")
  `STT_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(DEPTH), "queue fill level beyond depth")

endmodule

### rtl/source_text_tokenizer_top.sv
// Source text tokenizer: bytes in, tokens and status results out.
// Each result is written into the result queue when the byte that causes it is taken.
// Throughput: one byte per cycle; a byte causing two results adds two queue entries,
// and input stalls while the four-entry result queue has fewer than two free slots.
// Reset (synchronous, active low) sets line 1, column 1, offset 0 and empties the
// queue; an end mark brings the scanner back to the same state.
module source_text_tokenizer_top #(
  parameter int KEYWORD_CHARS = 6,
  parameter int LINE_BITS     = 24,
  parameter int COLUMN_BITS   = 16,
  parameter int OFFSET_BITS   = 32,
  parameter int LENGTH_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_char_byte,
  input  logic                   in_end_of_source,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             out_status,
  output logic [5:0]             out_token_kind,
  output logic [LINE_BITS-1:0]   out_line_number,
  output logic [COLUMN_BITS-1:0] out_start_column,
  output logic [OFFSET_BITS-1:0] out_text_offset,
  output logic [LENGTH_BITS-1:0] out_text_length,
  output logic                   out_last_of_run
);

  localparam int RW = stt_pkg::STATUS_BITS + stt_pkg::KIND_BITS + LINE_BITS +
                      COLUMN_BITS + OFFSET_BITS + LENGTH_BITS + 1;
  localparam int QUEUE_DEPTH = 4;

  stt_pkg::push_t push;
  logic [RW-1:0]  res_a;
  logic [RW-1:0]  res_b;
  logic [RW-1:0]  q_data;
  logic           room;
  logic           accept;

  // input transaction
  assign in_stall = !room;
  assign accept   = in_valid && room;

  stt_core #(
    .KEYWORD_CHARS (KEYWORD_CHARS),
    .LINE_BITS     (LINE_BITS),
    .COLUMN_BITS   (COLUMN_BITS),
    .OFFSET_BITS   (OFFSET_BITS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .char_byte     (in_char_byte),
    .end_of_source (in_end_of_source),
    .push          (push),
    .res_a         (res_a),
    .res_b         (res_b)
  );

  stt_result_fifo #(
    .WIDTH (RW),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .data_a    (res_a),
    .data_b    (res_b),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (q_data),
    .room      (room)
  );

  // result fields
  assign {out_status, out_token_kind, out_line_number, out_start_column,
          out_text_offset, out_text_length, out_last_of_run} = q_data;

endmodule
